/* rtl/spq_pkg.sv */
// types and constants shared by the sorted priority queue modules
`default_nettype none

package spq_pkg;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] key;
      logic [15:0] id;
      logic [31:0] arrival;
      logic [31:0] run;
      logic [7:0]  prio;
   } entry_type;

   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type rec;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/spq_cell.sv */
// one slot of the sorted chain: holds an entry, shifts right on insert, left on removal
`default_nettype none

module spq_cell (
   input  wire logic               clock,
   input  wire spq_pkg::cmd_type   cmd,
   input  wire logic               is_head,
   input  wire logic               occupied,
   input  wire logic               left_ge,
   input  wire spq_pkg::entry_type left_entry,
   input  wire spq_pkg::entry_type right_entry,
   output logic                    ge,
   output spq_pkg::entry_type      entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // new key belongs at or before this slot
   always_comb begin
      if (!occupied) begin
         ge = 1'b1;
      end else if (is_head) begin
         ge = entry_ff.key > cmd.rec.key;
      end else begin
         ge = entry_ff.key >= cmd.rec.key;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq && ge) begin
         entry_in = left_ge ? left_entry : cmd.rec;
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// top level: sorted priority queue of process records built as a chain of slot cells
`default_nettype none

// Every accepted request (start high, busy low) gives exactly one result in
// the next cycle: rsp_valid is high for that one cycle and the rsp_ ports hold
// the status, the removed record (zero unless a dequeue succeeded), and the
// count and head after the request. busy stays low, so a request may be issued
// in every cycle: all DEPTH cells compare their key with the new key at once
// and shift in a single step. Results cannot be held off, so the receiver must
// take each one in the cycle it appears.

module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [15:0] req_key,
   input  wire logic [15:0] req_proc_id,
   input  wire logic [31:0] req_arrival_time,
   input  wire logic [31:0] req_run_time,
   input  wire logic [7:0]  req_proc_priority,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_key,
   output logic [15:0]      rsp_out_id,
   output logic [31:0]      rsp_out_arrival,
   output logic [31:0]      rsp_out_run,
   output logic [7:0]       rsp_out_prio,
   output logic             rsp_is_empty,
   output logic [4:0]       rsp_entry_count,
   output logic [15:0]      rsp_head_key,
   output logic [15:0]      rsp_head_id
);

   localparam int CntW = $clog2(DEPTH + 1);

   logic [CntW-1:0]    count_ff;
   logic [CntW-1:0]    count_in;
   logic               valid_ff;
   spq_pkg::status_type status_ff;
   spq_pkg::status_type status_in;
   spq_pkg::entry_type out_ff;
   spq_pkg::entry_type out_in;

   spq_pkg::cmd_type   cmd;
   logic               accept;
   logic               full;
   logic               empty;

   spq_pkg::entry_type cell_entry [DEPTH];
   logic [DEPTH-1:0]   cell_ge;

   logic [CntW+4:0]    count_ext;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = count_ff == CntW'(DEPTH);
   assign empty  = count_ff == '0;

   always_comb begin
      cmd.rec.key     = req_key;
      cmd.rec.id      = req_proc_id;
      cmd.rec.arrival = req_arrival_time;
      cmd.rec.run     = req_run_time;
      cmd.rec.prio    = req_proc_priority;
      cmd.enq         = accept && (req_op == spq_pkg::OP_ENQ) && !full;
      cmd.deq         = accept && (req_op == spq_pkg::OP_DEQ) && !empty;
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .is_head     (i == 0),
            .occupied    (count_ff > CntW'(i)),
            .left_ge     ((i == 0) ? 1'b0 : cell_ge[(i == 0) ? 0 : i - 1]),
            .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
            .ge          (cell_ge[i]),
            .entry       (cell_entry[i])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::ST_OK;
      out_in    = '0;
      if (cmd.enq) begin
         count_in = count_ff + CntW'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - CntW'(1);
         out_in   = cell_entry[0];
      end else if (accept) begin
         status_in = (req_op == spq_pkg::OP_DEQ) ? spq_pkg::ST_EMPTY : spq_pkg::ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign count_ext = {5'b0, count_ff};

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key     = out_ff.key;
   assign rsp_out_id      = out_ff.id;
   assign rsp_out_arrival = out_ff.arrival;
   assign rsp_out_run     = out_ff.run;
   assign rsp_out_prio    = out_ff.prio;
   assign rsp_is_empty    = empty;
   assign rsp_entry_count = count_ext[4:0];
   assign rsp_head_key    = empty ? 16'd0 : cell_entry[0].key;
   assign rsp_head_id     = empty ? 16'd0 : cell_entry[0].id;

endmodule

`default_nettype wire

/* tb/queue_mirror_pkg.sv */
// expected-response model of the sorted priority queue, kept as a small scoreboard class
`timescale 1ns / 100ps

package queue_mirror_pkg;

   import spq_pkg::*;

   localparam int QUEUE_DEPTH = 16;

   typedef struct packed {
      status_type  status;
      entry_type   rec;
      logic        is_empty;
      logic [4:0]  count;
      logic [15:0] head_key;
      logic [15:0] head_id;
   } response_type;

   class queue_mirror;
      entry_type    slots[QUEUE_DEPTH];
      int           fill;
      response_type awaited[$];
      int           errors;
      int           checked;
      int           enq_done;
      int           deq_done;
      int           full_refusals;
      int           empty_misses;

      function new();
         fill = 0;
         errors = 0;
         checked = 0;
         enq_done = 0;
         deq_done = 0;
         full_refusals = 0;
         empty_misses = 0;
      endfunction

      function void note_request(logic op, entry_type rec);
         response_type r;
         int pos;
         int i;
         r = '0;
         r.status = ST_OK;
         if (op == OP_ENQ) begin
            if (fill >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
               full_refusals++;
            end else begin
               if (fill == 0 || slots[0].key > rec.key) begin
                  pos = 0;
               end else begin
                  pos = 1;
                  while (pos < fill && slots[pos].key < rec.key) pos++;
               end
               for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
               slots[pos] = rec;
               fill++;
               enq_done++;
            end
         end else begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
               empty_misses++;
            end else begin
               r.rec = slots[0];
               for (i = 1; i < fill; i++) slots[i - 1] = slots[i];
               fill--;
               deq_done++;
            end
         end
         r.is_empty = (fill == 0);
         r.count = 5'(fill);
         if (fill != 0) begin
            r.head_key = slots[0].key;
            r.head_id = slots[0].id;
         end
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (awaited.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("out_key", 32'(want.rec.key), 32'(got.rec.key));
         compare_field("out_id", 32'(want.rec.id), 32'(got.rec.id));
         compare_field("out_arrival", want.rec.arrival, got.rec.arrival);
         compare_field("out_run", want.rec.run, got.rec.run);
         compare_field("out_prio", 32'(want.rec.prio), 32'(got.rec.prio));
         compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
         compare_field("entry_count", 32'(want.count), 32'(got.count));
         compare_field("head_key", 32'(want.head_key), 32'(got.head_key));
         compare_field("head_id", 32'(want.head_id), 32'(got.head_id));
      endfunction
   endclass

endpackage

/* tb/testbench.sv */
// testbench for the sorted priority queue: directed and random requests checked against a mirror
`timescale 1ns / 100ps

module testbench;

   import spq_pkg::*;
   import queue_mirror_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_op;
   logic [15:0] req_key;
   logic [15:0] req_proc_id;
   logic [31:0] req_arrival_time;
   logic [31:0] req_run_time;
   logic [7:0]  req_proc_priority;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_key;
   logic [15:0] rsp_out_id;
   logic [31:0] rsp_out_arrival;
   logic [31:0] rsp_out_run;
   logic [7:0]  rsp_out_prio;
   logic        rsp_is_empty;
   logic [4:0]  rsp_entry_count;
   logic [15:0] rsp_head_key;
   logic [15:0] rsp_head_id;

   queue_mirror  mirror;
   response_type seen;
   entry_type    taken;
   int           sent;

   sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_key(req_key),
      .req_proc_id(req_proc_id),
      .req_arrival_time(req_arrival_time),
      .req_run_time(req_run_time),
      .req_proc_priority(req_proc_priority),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key),
      .rsp_out_id(rsp_out_id),
      .rsp_out_arrival(rsp_out_arrival),
      .rsp_out_run(rsp_out_run),
      .rsp_out_prio(rsp_out_prio),
      .rsp_is_empty(rsp_is_empty),
      .rsp_entry_count(rsp_entry_count),
      .rsp_head_key(rsp_head_key),
      .rsp_head_id(rsp_head_id)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid) begin
            seen.status = status_type'(rsp_status);
            seen.rec.key = rsp_out_key;
            seen.rec.id = rsp_out_id;
            seen.rec.arrival = rsp_out_arrival;
            seen.rec.run = rsp_out_run;
            seen.rec.prio = rsp_out_prio;
            seen.is_empty = rsp_is_empty;
            seen.count = rsp_entry_count;
            seen.head_key = rsp_head_key;
            seen.head_id = rsp_head_id;
            mirror.check_response(seen);
         end
         if (start && !busy) begin
            taken.key = req_key;
            taken.id = req_proc_id;
            taken.arrival = req_arrival_time;
            taken.run = req_run_time;
            taken.prio = req_proc_priority;
            mirror.note_request(req_op, taken);
         end
      end
   end

   task automatic issue(logic op, logic [15:0] key, logic [15:0] id, logic [31:0] arrival,
                        logic [31:0] run, logic [7:0] prio);
      start <= 1'b1;
      req_op <= op;
      req_key <= key;
      req_proc_id <= id;
      req_arrival_time <= arrival;
      req_run_time <= run;
      req_proc_priority <= prio;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   task automatic issue_random(logic op, logic [15:0] key);
      issue(op, key, 16'($urandom), $urandom, $urandom, 8'($urandom));
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_key();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 7));
         1: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int   phase_len;
      int   enq_weight;
      int   burst;
      bit   no_idle;
      logic op;
      mirror = new();
      sent = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= OP_ENQ;
      req_key <= '0;
      req_proc_id <= '0;
      req_arrival_time <= '0;
      req_run_time <= '0;
      req_proc_priority <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      issue_random(OP_DEQ, 16'h0000);
      issue(OP_ENQ, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 8'hff);
      issue(OP_ENQ, 16'h0000, 16'h0000, 32'h0, 32'h0, 8'h00);
      issue(OP_ENQ, 16'h0000, 16'h1111, 32'h1111, 32'h1111, 8'h11);
      issue(OP_ENQ, 16'h8000, 16'h2222, 32'h2222, 32'h2222, 8'h22);
      issue(OP_ENQ, 16'h8000, 16'h3333, 32'h3333, 32'h3333, 8'h33);
      issue_random(OP_DEQ, 16'hffff);
      for (int i = 0; i < 12; i++) issue_random(OP_ENQ, pick_key());
      issue_random(OP_ENQ, 16'h0000);
      pause(3);
      issue_random(OP_DEQ, 16'h0000);
      issue_random(OP_DEQ, 16'h0000);

      // random part: fill-heavy, drain-heavy and balanced phases
      while (sent < 520) begin
         phase_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: enq_weight = 80;
            1: enq_weight = 20;
            default: enq_weight = 50;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         while (phase_len > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && phase_len > 0) begin
               op = ($urandom_range(1, 100) <= enq_weight) ? OP_ENQ : OP_DEQ;
               issue_random(op, pick_key());
               burst--;
               phase_len--;
            end
            if (!no_idle) pause($urandom_range(0, 6));
         end
      end
      start <= 1'b0;

      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("covered %0d requests: %0d enqueues, %0d dequeues, %0d full refusals,",
               sent, mirror.enq_done, mirror.deq_done, mirror.full_refusals);
      $display("%0d dequeues on empty, %0d responses checked",
               mirror.empty_misses, mirror.checked);
      if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/queue_mirror_pkg.sv
tb/testbench.sv
